>>> rtl/bci_pkg.sv
package bci_pkg;

  localparam int COORD_WIDTH      = 16;
  localparam int WEIGHT_FRAC_BITS = 16;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] CHAN_MAX     = 8'd255;

  typedef enum logic [2:0] {
    REG_V0_POS = 3'd0,
    REG_V1_POS = 3'd1,
    REG_V2_POS = 3'd2,
    REG_V0_COL = 3'd3,
    REG_V1_COL = 3'd4,
    REG_V2_COL = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
  } in_t;

  typedef struct packed {
    logic [31:0] argb_color;
    logic        degenerate;
  } out_t;

endpackage

>>> rtl/barycentric_color_interpolator.sv
// Barycentric Gouraud color interpolator. The three vertex positions (signed
// Q12.4) and RGB colors are written through the configuration port while the
// block is idle. Each input transaction carries one pixel position and yields
// exactly one output transaction: the opaque ARGB color blended with weights
// alpha, beta and gamma, or opaque black with the degenerate flag when the
// triangle has zero area. The block accepts one pixel every clock cycle while
// the output is not stalled; the two pipelined dividers resolve one quotient
// bit per stage. A stalled output freezes the whole pipeline, so no
// transaction is lost or repeated.
module barycentric_color_interpolator #(
  parameter int COORD_WIDTH      = bci_pkg::COORD_WIDTH,
  parameter int WEIGHT_FRAC_BITS = bci_pkg::WEIGHT_FRAC_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bci_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bci_pkg::out_t out_data_o
);

  localparam int CW  = COORD_WIDTH;
  localparam int F   = WEIGHT_FRAC_BITS;
  localparam int PW  = 2 * CW + 1;   // one product term
  localparam int EW  = 2 * CW + 3;   // edge function
  localparam int NW  = EW + F;       // scaled numerator magnitude
  localparam int QB  = F + 2;        // quotient bits, also weight width
  localparam int WW  = QB;
  localparam int PRW = WW + 9;       // color times weight
  localparam int SW  = WW + 11;      // sum of three products
  localparam int TW  = SW - F;       // sum after the fraction shift

  localparam logic [QB-1:0]        MAG_MAX = {2'b01, {F{1'b1}}};
  localparam logic [QB-1:0]        MAG_MIN = {2'b10, {F{1'b0}}};
  localparam logic signed [WW-1:0] W_MAX   = {2'b01, {F{1'b1}}};
  localparam logic signed [WW-1:0] W_MIN   = {2'b10, {F{1'b0}}};
  localparam logic signed [WW+1:0] ONE_G   = (WW + 2)'(1) << F;

  // Configuration registers.
  logic [31:0] pos_q [3];
  logic [23:0] col_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
        col_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (bci_pkg::cfg_reg_e'(cfg_index_i))
        bci_pkg::REG_V0_POS: pos_q[0] <= cfg_data_i;
        bci_pkg::REG_V1_POS: pos_q[1] <= cfg_data_i;
        bci_pkg::REG_V2_POS: pos_q[2] <= cfg_data_i;
        bci_pkg::REG_V0_COL: col_q[0] <= cfg_data_i[23:0];
        bci_pkg::REG_V1_COL: col_q[1] <= cfg_data_i[23:0];
        bci_pkg::REG_V2_COL: col_q[2] <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // Vertex coordinates, taken as CW-bit two's complement values.
  logic signed [CW-1:0] vx [3];
  logic signed [CW-1:0] vy [3];
  for (genvar v = 0; v < 3; v++) begin : g_vtx
    logic [15:0] hx, hy;
    assign hx    = pos_q[v][31:16];
    assign hy    = pos_q[v][15:0];
    assign vx[v] = CW'(hx);
    assign vy[v] = CW'(hy);
  end

  // The whole pipeline advances together unless the output is blocked.
  logic adv;
  logic out_valid_q;
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // Stage 0: capture the pixel.
  logic                 v0_q;
  logic signed [CW-1:0] px_q, py_q;
  logic signed [15:0]   in_x, in_y;
  assign in_x = in_data_i.pixel_x;
  assign in_y = in_data_i.pixel_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q <= CW'(in_x);
      py_q <= CW'(in_y);
    end
  end

  // Stage 1: every product term of both edge functions and the denominator.
  logic signed [CW:0] dy12, dx21, dy20, dx02;
  assign dy12 = (CW + 1)'(vy[1]) - (CW + 1)'(vy[2]);
  assign dx21 = (CW + 1)'(vx[2]) - (CW + 1)'(vx[1]);
  assign dy20 = (CW + 1)'(vy[2]) - (CW + 1)'(vy[0]);
  assign dx02 = (CW + 1)'(vx[0]) - (CW + 1)'(vx[2]);

  logic              v1_q;
  logic signed [PW-1:0] e0a_q, e0b_q, e0c_q, e0d_q;
  logic signed [PW-1:0] e1a_q, e1b_q, e1c_q, e1d_q;
  logic signed [PW-1:0] da_q, db_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e0a_q <= dy12 * px_q;
      e0b_q <= dx21 * py_q;
      e0c_q <= PW'(vx[1] * vy[2]);
      e0d_q <= PW'(vx[2] * vy[1]);
      e1a_q <= dy20 * px_q;
      e1b_q <= dx02 * py_q;
      e1c_q <= PW'(vx[2] * vy[0]);
      e1d_q <= PW'(vx[0] * vy[2]);
      da_q  <= dy12 * vx[0];
      db_q  <= dx21 * vy[0];
    end
  end

  // Stage 2: edge function sums. The one denominator, shared by both dividers, equals twice the area.
  logic              v2_q;
  logic signed [EW-1:0] e0_q, e1_q, den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e0_q  <= EW'(e0a_q) + EW'(e0b_q) + EW'(e0c_q) - EW'(e0d_q);
      e1_q  <= EW'(e1a_q) + EW'(e1b_q) + EW'(e1c_q) - EW'(e1d_q);
      den_q <= EW'(da_q) + EW'(db_q) + EW'(e0c_q) - EW'(e0d_q);
    end
  end

  // Magnitudes and signs for the dividers.
  logic          s_e0, s_e1, s_den;
  logic [EW-1:0] m_e0, m_e1, m_den;
  assign s_e0  = e0_q[EW-1];
  assign s_e1  = e1_q[EW-1];
  assign s_den = den_q[EW-1];
  assign m_e0  = s_e0  ? EW'(0) - e0_q  : e0_q;
  assign m_e1  = s_e1  ? EW'(0) - e1_q  : e1_q;
  assign m_den = s_den ? EW'(0) - den_q : den_q;

  logic [QB-1:0] qa, qb;
  logic          ova, ovb;

  bci_divider #(.NW(NW), .DMW(EW), .QB(QB)) u_div_alpha (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i ({m_e0, F'(0)}),
    .den_i (m_den),
    .quo_o (qa),
    .ovf_o (ova)
  );

  bci_divider #(.NW(NW), .DMW(EW), .QB(QB)) u_div_beta (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i ({m_e1, F'(0)}),
    .den_i (m_den),
    .quo_o (qb),
    .ovf_o (ovb)
  );

  // Sideband that travels alongside the divider stages.
  logic sd_v_q   [QB+1];
  logic sd_sa_q  [QB+1];
  logic sd_sb_q  [QB+1];
  logic sd_deg_q [QB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QB; k++) sd_v_q[k] <= 1'b0;
    end else if (adv) begin
      sd_v_q[0] <= v2_q;
      for (int k = 1; k <= QB; k++) sd_v_q[k] <= sd_v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_sa_q[0]  <= s_e0 ^ s_den;
      sd_sb_q[0]  <= s_e1 ^ s_den;
      sd_deg_q[0] <= (den_q == '0);
      for (int k = 1; k <= QB; k++) begin
        sd_sa_q[k]  <= sd_sa_q[k-1];
        sd_sb_q[k]  <= sd_sb_q[k-1];
        sd_deg_q[k] <= sd_deg_q[k-1];
      end
    end
  end

  // Signed, saturated Q2.F weight from a truncated quotient magnitude.
  function automatic logic signed [WW-1:0] sat_weight(input logic ovf, input logic neg,
                                                      input logic [QB-1:0] mag);
    logic signed [WW-1:0] w;
    if (!neg) begin
      w = (ovf || mag > MAG_MAX) ? W_MAX : WW'(mag);
    end else begin
      w = (ovf || mag > MAG_MIN) ? W_MIN : WW'(QB'(0) - mag);
    end
    return w;
  endfunction

  // Post stage 1: alpha and beta.
  logic                 p1_v_q, p1_deg_q;
  logic signed [WW-1:0] p1_a_q, p1_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (adv) begin
      p1_v_q <= sd_v_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_deg_q <= sd_deg_q[QB];
      p1_a_q   <= sat_weight(ova, sd_sa_q[QB], qa);
      p1_b_q   <= sat_weight(ovb, sd_sb_q[QB], qb);
    end
  end

  // Post stage 2: gamma is one minus the other two, saturated.
  logic signed [WW+1:0] g_raw;
  assign g_raw = ONE_G - (WW + 2)'(p1_a_q) - (WW + 2)'(p1_b_q);

  logic                 p2_v_q, p2_deg_q;
  logic signed [WW-1:0] p2_w_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
    end else if (adv) begin
      p2_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p2_deg_q  <= p1_deg_q;
      p2_w_q[0] <= p1_a_q;
      p2_w_q[1] <= p1_b_q;
      if (g_raw > (WW + 2)'(W_MAX)) begin
        p2_w_q[2] <= W_MAX;
      end else if (g_raw < (WW + 2)'(W_MIN)) begin
        p2_w_q[2] <= W_MIN;
      end else begin
        p2_w_q[2] <= WW'(g_raw);
      end
    end
  end

  // Post stage 3: nine color-by-weight products, channel c, vertex v.
  logic                  p3_v_q, p3_deg_q;
  logic signed [PRW-1:0] p3_prod_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_v_q <= 1'b0;
    end else if (adv) begin
      p3_v_q <= p2_v_q;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_chan
    for (genvar v = 0; v < 3; v++) begin : g_vert
      logic signed [8:0] cs;
      assign cs = {1'b0, col_q[v][8*c +: 8]};
      always_ff @(posedge clk_i) begin
        if (adv) begin
          p3_prod_q[c][v] <= cs * p2_w_q[v];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p3_deg_q <= p2_deg_q;
    end
  end

  // Post stage 4: sum, drop the fraction, clamp, and pack the output.
  logic [7:0] chan [3];
  for (genvar c = 0; c < 3; c++) begin : g_clamp
    logic signed [SW-1:0] sum;
    logic        [TW-1:0] top;
    assign sum = SW'(p3_prod_q[c][0]) + SW'(p3_prod_q[c][1]) + SW'(p3_prod_q[c][2]);
    assign top = sum[SW-1:F];
    always_comb begin
      if (sum[SW-1]) begin
        chan[c] = '0;
      end else if (top > TW'(bci_pkg::CHAN_MAX)) begin
        chan[c] = bci_pkg::CHAN_MAX;
      end else begin
        chan[c] = top[7:0];
      end
    end
  end

  bci_pkg::out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= p3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.degenerate <= p3_deg_q;
      if (p3_deg_q) begin
        out_q.argb_color <= {bci_pkg::ALPHA_OPAQUE, 24'h0};
      end else begin
        out_q.argb_color <= {bci_pkg::ALPHA_OPAQUE, chan[2], chan[1], chan[0]};
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A degenerate triangle always shades opaque black.
  a_degen_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |-> out_data_o.argb_color == 32'hFF000000)
    else $error("degenerate result is not opaque black");

  // An accepted pixel shows up in the first pipeline stage.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> v0_q)
    else $error("accepted pixel did not enter the pipeline");

  // The input only stalls while a finished result waits.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked output");

  // A frozen pipeline keeps the valid bits of stage 0 and post stage 1.
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(v0_q) && $stable(p1_v_q))
    else $error("pipeline moved while stalled");

endmodule

>>> rtl/bci_divider.sv
// Pipelined restoring divider for magnitudes, one quotient bit per stage.
// The quotient is only QB bits wide; ovf_o flags a quotient that does not fit.
module bci_divider #(
  parameter int NW  = 51,
  parameter int DMW = 35,
  parameter int QB  = 18
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [NW-1:0]  num_i,
  input  logic [DMW-1:0] den_i,
  output logic [QB-1:0]  quo_o,
  output logic           ovf_o
);

  localparam int RW = DMW + QB + 1;

  logic [RW-1:0]  rem_q [QB+1];
  logic [DMW-1:0] den_q [QB+1];
  logic [QB-1:0]  quo_q [QB+1];
  logic           ovf_q [QB+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= RW'(num_i);
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= (RW'(num_i) >= (RW'(den_i) << QB));
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [RW-1:0] sh;
    logic [RW:0]   trial;
    assign sh    = RW'(den_q[k-1]) << (QB - k);
    assign trial = {1'b0, rem_q[k-1]} - {1'b0, sh};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= trial[RW] ? rem_q[k-1] : trial[RW-1:0];
        den_q[k] <= den_q[k-1];
        quo_q[k] <= {quo_q[k-1][QB-2:0], ~trial[RW]};
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign quo_o = quo_q[QB];
  assign ovf_o = ovf_q[QB];

endmodule
